@@ hw/rtl/msbc_pkg.sv @@
// ----------------------------------------------------------------------------
// msbc_pkg - shared definitions for the record merge sorter
// Field widths, mode codes, stack frame phases and sequencer states.
// ----------------------------------------------------------------------------
package msbc_pkg;

  localparam int KEY_W = 32;
  localparam int TAG_W = 32;
  localparam int TOT_W = 32;
  localparam int REC_W = KEY_W + TAG_W;

  localparam logic MODE_LOAD = 1'b0;
  localparam logic MODE_READ = 1'b1;

  typedef logic [1:0] phase_t;
  localparam phase_t PH_LEFT  = 2'd0;
  localparam phase_t PH_RIGHT = 2'd1;
  localparam phase_t PH_MERGE = 2'd2;

  typedef enum logic [7:0] {
    ST_IDLE  = 8'b0000_0001,
    ST_RDW   = 8'b0000_0010,
    ST_RDO   = 8'b0000_0100,
    ST_FRAME = 8'b0000_1000,
    ST_CPY   = 8'b0001_0000,
    ST_CPD   = 8'b0010_0000,
    ST_MRD   = 8'b0100_0000,
    ST_MCMP  = 8'b1000_0000
  } state_t;

endpackage

@@ hw/rtl/msbc_in_if.sv @@
// ----------------------------------------------------------------------------
// msbc_in_if - input channel of the record merge sorter
// Valid/ready channel carrying one load or read request per beat.
// ----------------------------------------------------------------------------
interface msbc_in_if;

  logic                       valid;
  logic                       ready;
  logic                       mode;
  logic [msbc_pkg::KEY_W-1:0] record_key;
  logic [msbc_pkg::TAG_W-1:0] record_tag;
  logic                       last_record;

  modport source (output valid, mode, record_key, record_tag, last_record, input ready);
  modport sink   (input valid, mode, record_key, record_tag, last_record, output ready);

endinterface

@@ hw/rtl/msbc_out_if.sv @@
// ----------------------------------------------------------------------------
// msbc_out_if - result channel of the record merge sorter
// Valid/ready channel carrying one sorted record and the sort totals per beat.
// ----------------------------------------------------------------------------
interface msbc_out_if;

  logic                       valid;
  logic                       ready;
  logic [msbc_pkg::KEY_W-1:0] sorted_key;
  logic [msbc_pkg::TAG_W-1:0] sorted_tag;
  logic                       is_last;
  logic [msbc_pkg::TOT_W-1:0] comparisons_total;
  logic [msbc_pkg::TOT_W-1:0] moves_total;
  logic                       overflowed;

  modport source (output valid, sorted_key, sorted_tag, is_last, comparisons_total,
                  moves_total, overflowed, input ready);
  modport sink   (input valid, sorted_key, sorted_tag, is_last, comparisons_total,
                  moves_total, overflowed, output ready);

endinterface

@@ hw/rtl/merge_sort_by_count.sv @@
// ----------------------------------------------------------------------------
// merge_sort_by_count - record sorter, ascending top-down merge sort
// Loads records, sorts them by key on the last load and returns them in order.
// ----------------------------------------------------------------------------
// Load beats (mode 0) write one record each into the record store; a load
// beyond MAX_RECORDS is dropped and sets the overflow flag. The load marked
// last starts the sort, during which in_ch.ready is low. Read beats (mode 1)
// return one sorted record each, with the comparison and move totals; a read
// before a sort or past the end of the batch gives no result. The first load
// after a sort starts a new batch. A read passes the read address register,
// the store read and the output register, and is held while the result
// register is full. The sort runs on one shared key comparator under a
// frame stack sequencer: each merge of a range first copies the range to
// scratch (one store read port), then drains, then places each record with
// a registered scratch read followed by a compare and write back, and
// closes; each range also passes through its frame steps (left, right,
// merge). The stores need no clearing pass: only entries already loaded
// are ever read.
// ----------------------------------------------------------------------------
module merge_sort_by_count #(
  parameter int MAX_RECORDS = 1024,
  parameter int STACK_DEPTH = 11
) (
  input  logic       clk,
  input  logic       rst_n,
  msbc_in_if.sink    in_ch,
  msbc_out_if.source out_ch
);

  localparam int AW  = $clog2(MAX_RECORDS);       // store index
  localparam int CW  = $clog2(MAX_RECORDS + 1);   // count, may equal depth
  localparam int SPW = $clog2(STACK_DEPTH + 1);   // stack pointer
  localparam int SIW = $clog2(STACK_DEPTH);       // stack index

  localparam int KW = msbc_pkg::KEY_W;
  localparam int TW = msbc_pkg::TAG_W;
  localparam int RW = msbc_pkg::REC_W;
  localparam int OW = msbc_pkg::TOT_W;

  typedef struct packed {
    logic [AW-1:0]    lo;
    logic [AW-1:0]    hi;
    msbc_pkg::phase_t phase;
  } frame_t;

  // Stores: record store (one read, one write port) and merge scratch
  // (two read ports for the run heads, one write port for the copy).
  logic [RW-1:0] store_mem   [MAX_RECORDS];
  logic [RW-1:0] scratch_mem [MAX_RECORDS];
  frame_t        stack_r     [STACK_DEPTH];

  logic [RW-1:0] store_rd_r, scr_l_r, scr_r_r;

  msbc_pkg::state_t state_r, state_nxt;
  logic [CW-1:0]  count_r, count_nxt;
  logic [CW-1:0]  rdpos_r, rdpos_nxt;
  logic [OW-1:0]  cmp_r, cmp_nxt;
  logic [OW-1:0]  mov_r, mov_nxt;
  logic           ovf_r, ovf_nxt;
  logic           done_r, done_nxt;
  logic [SPW-1:0] sp_r, sp_nxt;

  // Merge and copy pointers
  logic [CW-1:0]  i_r, i_nxt, j_r, j_nxt, k_r, k_nxt, c_r, c_nxt;
  logic [CW-1:0]  mid_r, mid_nxt, hi_r, hi_nxt;

  logic [AW-1:0]  rd_addr_r, rd_addr_nxt;
  logic           rd_last_r, rd_last_nxt;
  logic           cp_vld_r;
  logic [AW-1:0]  cp_addr_r;

  // Result register
  logic           out_vld_r, out_vld_nxt;
  logic [KW-1:0]  out_key_r;
  logic [TW-1:0]  out_tag_r;
  logic           out_last_r;
  logic [OW-1:0]  out_cmp_r, out_mov_r;
  logic           out_ovf_r;
  logic           out_load;

  logic           accept;
  logic [CW-1:0]  count_eff, load_count;
  logic           has_room;
  logic [SPW-1:0] sp_dec;
  logic [SIW-1:0] top_idx;
  frame_t         top_f;
  logic [AW:0]    mid_sum;
  logic [AW-1:0]  top_mid;
  logic [AW-1:0]  push_lo, push_hi;
  logic           push_ok, frame_adv, sort_start;
  logic           left_ok, right_ok, take_left;

  logic           st_we;
  logic [AW-1:0]  st_waddr, st_raddr;
  logic [RW-1:0]  st_wdata;

  assign in_ch.ready = (state_r == msbc_pkg::ST_IDLE);
  assign accept      = in_ch.valid && in_ch.ready;

  // A finished batch is discarded by the next load
  assign count_eff  = done_r ? '0 : count_r;
  assign has_room   = (count_eff < CW'(MAX_RECORDS));
  assign load_count = count_eff + CW'(has_room);

  // Top of stack and its split point
  assign sp_dec  = sp_r - SPW'(1);
  assign top_idx = sp_dec[SIW-1:0];
  assign top_f   = stack_r[top_idx];
  assign mid_sum = {1'b0, top_f.lo} + {1'b0, top_f.hi};
  assign top_mid = mid_sum[AW:1];

  always_comb begin
    if (top_f.phase == msbc_pkg::PH_LEFT) begin
      push_lo = top_f.lo;
      push_hi = top_mid;
    end else begin
      push_lo = top_mid + AW'(1);
      push_hi = top_f.hi;
    end
  end

  // Ranges of one record, or that find the stack full, are not pushed
  assign push_ok   = (push_hi > push_lo) && (sp_r < SPW'(STACK_DEPTH));
  assign frame_adv = (state_r == msbc_pkg::ST_FRAME) && (sp_r != '0) &&
                     ((top_f.phase == msbc_pkg::PH_LEFT) ||
                      (top_f.phase == msbc_pkg::PH_RIGHT));
  assign sort_start = accept && (in_ch.mode == msbc_pkg::MODE_LOAD) &&
                      in_ch.last_record && (load_count >= CW'(2));

  // Shared comparator: left head wins only on a strictly smaller key
  assign left_ok   = (i_r <= mid_r);
  assign right_ok  = (j_r <= hi_r);
  assign take_left = left_ok &&
                     (!right_ok || (scr_l_r[RW-1:TW] < scr_r_r[RW-1:TW]));

  assign out_load = (state_r == msbc_pkg::ST_RDO) && (!out_vld_r || out_ch.ready);

  // Sequencer
  always_comb begin
    state_nxt   = state_r;
    count_nxt   = count_r;
    rdpos_nxt   = rdpos_r;
    cmp_nxt     = cmp_r;
    mov_nxt     = mov_r;
    ovf_nxt     = ovf_r;
    done_nxt    = done_r;
    sp_nxt      = sp_r;
    i_nxt       = i_r;
    j_nxt       = j_r;
    k_nxt       = k_r;
    c_nxt       = c_r;
    mid_nxt     = mid_r;
    hi_nxt      = hi_r;
    rd_addr_nxt = rd_addr_r;
    rd_last_nxt = rd_last_r;
    unique case (state_r)
      msbc_pkg::ST_IDLE: begin
        if (accept) begin
          if (in_ch.mode == msbc_pkg::MODE_LOAD) begin
            count_nxt = load_count;
            rdpos_nxt = '0;
            ovf_nxt   = (done_r ? 1'b0 : ovf_r) | !has_room;
            done_nxt  = in_ch.last_record;
            if (done_r || in_ch.last_record) begin
              cmp_nxt = '0;
              mov_nxt = '0;
            end
            if (sort_start) begin
              sp_nxt    = SPW'(1);
              state_nxt = msbc_pkg::ST_FRAME;
            end
          end else if (done_r && (rdpos_r < count_r)) begin
            rd_addr_nxt = rdpos_r[AW-1:0];
            rd_last_nxt = ((rdpos_r + CW'(1)) == count_r);
            rdpos_nxt   = rdpos_r + CW'(1);
            state_nxt   = msbc_pkg::ST_RDW;
          end
        end
      end
      msbc_pkg::ST_RDW: begin
        state_nxt = msbc_pkg::ST_RDO;
      end
      msbc_pkg::ST_RDO: begin
        if (out_load) begin
          state_nxt = msbc_pkg::ST_IDLE;
        end
      end
      msbc_pkg::ST_FRAME: begin
        if (sp_r == '0) begin
          state_nxt = msbc_pkg::ST_IDLE;
        end else begin
          case (top_f.phase) inside
            msbc_pkg::PH_LEFT, msbc_pkg::PH_RIGHT: begin
              if (push_ok) begin
                sp_nxt = sp_r + SPW'(1);
              end
            end
            default: begin
              i_nxt     = CW'(top_f.lo);
              j_nxt     = CW'(top_mid) + CW'(1);
              k_nxt     = CW'(top_f.lo);
              c_nxt     = CW'(top_f.lo);
              mid_nxt   = CW'(top_mid);
              hi_nxt    = CW'(top_f.hi);
              state_nxt = msbc_pkg::ST_CPY;
            end
          endcase
        end
      end
      msbc_pkg::ST_CPY: begin
        c_nxt = c_r + CW'(1);
        if (c_r == hi_r) begin
          state_nxt = msbc_pkg::ST_CPD;
        end
      end
      msbc_pkg::ST_CPD: begin
        state_nxt = msbc_pkg::ST_MRD;
      end
      msbc_pkg::ST_MRD: begin
        if (!left_ok && !right_ok) begin
          sp_nxt    = sp_dec;
          state_nxt = msbc_pkg::ST_FRAME;
        end else begin
          state_nxt = msbc_pkg::ST_MCMP;
        end
      end
      msbc_pkg::ST_MCMP: begin
        if (left_ok && right_ok) begin
          cmp_nxt = cmp_r + OW'(1);
        end
        mov_nxt = mov_r + OW'(1);
        k_nxt   = k_r + CW'(1);
        if (take_left) begin
          i_nxt = i_r + CW'(1);
        end else begin
          j_nxt = j_r + CW'(1);
        end
        state_nxt = msbc_pkg::ST_MRD;
      end
      default: begin
        state_nxt = msbc_pkg::ST_IDLE;
      end
    endcase
  end

  assign out_vld_nxt = (out_vld_r && !out_ch.ready) || out_load;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= msbc_pkg::ST_IDLE;
      count_r   <= '0;
      rdpos_r   <= '0;
      cmp_r     <= '0;
      mov_r     <= '0;
      ovf_r     <= 1'b0;
      done_r    <= 1'b0;
      sp_r      <= '0;
      cp_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      count_r   <= count_nxt;
      rdpos_r   <= rdpos_nxt;
      cmp_r     <= cmp_nxt;
      mov_r     <= mov_nxt;
      ovf_r     <= ovf_nxt;
      done_r    <= done_nxt;
      sp_r      <= sp_nxt;
      cp_vld_r  <= (state_r == msbc_pkg::ST_CPY);
      out_vld_r <= out_vld_nxt;
    end
  end

  // Datapath registers, no reset
  always_ff @(posedge clk) begin
    i_r       <= i_nxt;
    j_r       <= j_nxt;
    k_r       <= k_nxt;
    c_r       <= c_nxt;
    mid_r     <= mid_nxt;
    hi_r      <= hi_nxt;
    rd_addr_r <= rd_addr_nxt;
    rd_last_r <= rd_last_nxt;
    cp_addr_r <= c_r[AW-1:0];
    if (out_load) begin
      out_key_r  <= store_rd_r[RW-1:TW];
      out_tag_r  <= store_rd_r[TW-1:0];
      out_last_r <= rd_last_r;
      out_cmp_r  <= cmp_r;
      out_mov_r  <= mov_r;
      out_ovf_r  <= ovf_r;
    end
  end

  // Frame stack: phase advance on the top, push above it
  always_ff @(posedge clk) begin
    if (sort_start) begin
      stack_r[0] <= '{lo: '0, hi: AW'(load_count - CW'(1)), phase: msbc_pkg::PH_LEFT};
    end
    if (frame_adv) begin
      stack_r[top_idx].phase <= (top_f.phase == msbc_pkg::PH_LEFT) ?
                                msbc_pkg::PH_RIGHT : msbc_pkg::PH_MERGE;
      if (push_ok) begin
        stack_r[sp_r[SIW-1:0]] <= '{lo: push_lo, hi: push_hi, phase: msbc_pkg::PH_LEFT};
      end
    end
  end

  // Record store ports
  assign st_we = (state_r == msbc_pkg::ST_MCMP) ||
                 (accept && (in_ch.mode == msbc_pkg::MODE_LOAD) && has_room);
  assign st_waddr = (state_r == msbc_pkg::ST_MCMP) ? k_r[AW-1:0] : count_eff[AW-1:0];
  assign st_wdata = (state_r == msbc_pkg::ST_MCMP) ? (take_left ? scr_l_r : scr_r_r) :
                    {in_ch.record_key, in_ch.record_tag};
  assign st_raddr = (state_r == msbc_pkg::ST_CPY) ? c_r[AW-1:0] : rd_addr_r;

  always_ff @(posedge clk) begin
    if (st_we) begin
      store_mem[st_waddr] <= st_wdata;
    end
    store_rd_r <= store_mem[st_raddr];
  end

  // Scratch: copy lands in the cycle after the store read
  always_ff @(posedge clk) begin
    if (cp_vld_r) begin
      scratch_mem[cp_addr_r] <= store_rd_r;
    end
    scr_l_r <= scratch_mem[i_r[AW-1:0]];
    scr_r_r <= scratch_mem[j_r[AW-1:0]];
  end

  assign out_ch.valid             = out_vld_r;
  assign out_ch.sorted_key        = out_key_r;
  assign out_ch.sorted_tag        = out_tag_r;
  assign out_ch.is_last           = out_last_r;
  assign out_ch.comparisons_total = out_cmp_r;
  assign out_ch.moves_total       = out_mov_r;
  assign out_ch.overflowed        = out_ovf_r;

  // Checks
  a_sp_bound: assert property (@(posedge clk) disable iff (!rst_n)
    sp_r <= SPW'(STACK_DEPTH))
    else $error("frame stack pointer beyond depth");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(MAX_RECORDS))
    else $error("record count beyond capacity");

  a_merge_inv: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == msbc_pkg::ST_MCMP) |->
      (({1'b0, k_r} + {1'b0, mid_r} + (CW+1)'(1)) == ({1'b0, i_r} + {1'b0, j_r})))
    else $error("merge pointers out of step");

  a_merge_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == msbc_pkg::ST_MCMP) |-> (k_r <= hi_r) && (left_ok || right_ok))
    else $error("merge write outside its range");

  a_sort_end: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == msbc_pkg::ST_FRAME) && (sp_r == '0)) |=> in_ch.ready)
    else $error("sorter not idle after empty stack");

endmodule

@@ tb/sort_scoreboard.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sort_check_pkg - behavioural record sorter and result checker
// Keeps its own copy of the record store and works out each sorted beat.
// ----------------------------------------------------------------------------
package sort_check_pkg;

  localparam int NREC       = 1024;
  localparam int NSTACK     = 11;
  localparam int REPORT_MAX = 10;
  localparam int KEY_HI     = msbc_pkg::REC_W - 1;
  localparam int KEY_LO     = msbc_pkg::TAG_W;

  typedef logic [msbc_pkg::REC_W-1:0] record_t;  // key in the upper half, tag below

  typedef struct {
    logic [msbc_pkg::KEY_W-1:0] key;
    logic [msbc_pkg::TAG_W-1:0] tag;
    logic                       last;
    logic [msbc_pkg::TOT_W-1:0] cmps;
    logic [msbc_pkg::TOT_W-1:0] moves;
    logic                       ovf;
  } sorted_beat_t;

  class sort_scoreboard;
    record_t                    store   [NREC];
    record_t                    scratch [NREC];
    int unsigned                count   = 0;
    int unsigned                rd_pos  = 0;
    logic [msbc_pkg::TOT_W-1:0] cmps    = '0;
    logic [msbc_pkg::TOT_W-1:0] moves   = '0;
    bit                         ovf     = 1'b0;
    bit                         sorted  = 1'b0;
    int unsigned                stack_lo [NSTACK];
    int unsigned                stack_hi [NSTACK];
    msbc_pkg::phase_t           stack_ph [NSTACK];
    int unsigned                sp;
    sorted_beat_t               pending [$];
    int unsigned                errors  = 0;

    function void report(string msg);
      errors++;
      if (errors <= REPORT_MAX) begin
        $display("[%0t] %s", $time, msg);
      end
    endfunction

    function void push_range(int unsigned lo, int unsigned hi);
      if (hi <= lo || sp >= NSTACK) begin
        return;
      end
      stack_lo[sp] = lo;
      stack_hi[sp] = hi;
      stack_ph[sp] = msbc_pkg::PH_LEFT;
      sp++;
    endfunction

    // strictly-less takes from the left run, so ties go right first
    function void merge_runs(int unsigned lo, int unsigned mid, int unsigned hi);
      int unsigned i;
      int unsigned j;
      int unsigned k;
      for (k = lo; k <= hi; k++) begin
        scratch[k] = store[k];
      end
      i = lo;
      j = mid + 1;
      k = lo;
      while (i <= mid && j <= hi) begin
        cmps++;
        if (scratch[i][KEY_HI:KEY_LO] < scratch[j][KEY_HI:KEY_LO]) begin
          store[k] = scratch[i];
          i++;
        end else begin
          store[k] = scratch[j];
          j++;
        end
        k++;
        moves++;
      end
      while (i <= mid) begin
        store[k] = scratch[i];
        i++;
        k++;
        moves++;
      end
      while (j <= hi) begin
        store[k] = scratch[j];
        j++;
        k++;
        moves++;
      end
    endfunction

    function void sort_batch();
      int unsigned lo;
      int unsigned hi;
      int unsigned mid;
      sp    = 0;
      cmps  = '0;
      moves = '0;
      if (count < 2) begin
        return;
      end
      push_range(0, count - 1);
      while (sp > 0) begin
        lo  = stack_lo[sp-1];
        hi  = stack_hi[sp-1];
        mid = (lo + hi) / 2;
        case (stack_ph[sp-1])
          msbc_pkg::PH_LEFT: begin
            stack_ph[sp-1] = msbc_pkg::PH_RIGHT;
            push_range(lo, mid);
          end
          msbc_pkg::PH_RIGHT: begin
            stack_ph[sp-1] = msbc_pkg::PH_MERGE;
            push_range(mid + 1, hi);
          end
          default: begin
            merge_runs(lo, mid, hi);
            sp--;
          end
        endcase
      end
    endfunction

    function void note_input(logic mode, logic [msbc_pkg::KEY_W-1:0] key,
                             logic [msbc_pkg::TAG_W-1:0] tag, logic last);
      sorted_beat_t beat;
      if (mode == msbc_pkg::MODE_LOAD) begin
        if (sorted) begin
          count  = 0;
          rd_pos = 0;
          cmps   = '0;
          moves  = '0;
          ovf    = 1'b0;
          sorted = 1'b0;
        end
        if (count < NREC) begin
          store[count] = {key, tag};
          count++;
        end else begin
          ovf = 1'b1;
        end
        if (last) begin
          sort_batch();
          rd_pos = 0;
          sorted = 1'b1;
        end
      end else if (sorted && rd_pos < count) begin
        beat.key   = store[rd_pos][KEY_HI:KEY_LO];
        beat.tag   = store[rd_pos][KEY_LO-1:0];
        beat.last  = (rd_pos + 1 == count);
        beat.cmps  = cmps;
        beat.moves = moves;
        beat.ovf   = ovf;
        pending.push_back(beat);
        rd_pos++;
      end
    endfunction

    function void check_result(sorted_beat_t got);
      sorted_beat_t want;
      if (pending.size() == 0) begin
        report($sformatf("unexpected beat: key %h tag %h", got.key, got.tag));
        return;
      end
      want = pending.pop_front();
      if (got.key !== want.key)
        report($sformatf("sorted_key: expected %h, got %h", want.key, got.key));
      if (got.tag !== want.tag)
        report($sformatf("sorted_tag: expected %h, got %h", want.tag, got.tag));
      if (got.last !== want.last)
        report($sformatf("is_last: expected %b, got %b", want.last, got.last));
      if (got.cmps !== want.cmps)
        report($sformatf("comparisons_total: expected %0d, got %0d", want.cmps, got.cmps));
      if (got.moves !== want.moves)
        report($sformatf("moves_total: expected %0d, got %0d", want.moves, got.moves));
      if (got.ovf !== want.ovf)
        report($sformatf("overflowed: expected %b, got %b", want.ovf, got.ovf));
    endfunction
  endclass

endpackage

@@ tb/tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb - testbench for merge_sort_by_count
// Loads batches of records, reads them back in sorted order and checks every
// result beat, totals included, against a behavioural sorter.
// ----------------------------------------------------------------------------
module tb;

  localparam int STALL_PCT      = 13;      // idle / stall chance per cycle, in %
  localparam int RANDOM_ITEMS   = 400;
  localparam int DRAIN_CYCLES   = 20;      // generous tail after the read path
  // longest quiet spell is the sort of a 64-record batch
  localparam int WATCHDOG_LIMIT = 20000;

  typedef enum int {KEYS_WIDE, KEYS_TIED, KEYS_EDGE} key_style_t;

  logic                           clk;
  logic                           rst_n;
  logic                           steady;   // no idling on either side while high
  int unsigned                    items_sent;
  int unsigned                    quiet_cycles = 0;
  sort_check_pkg::sort_scoreboard sorter;

  msbc_in_if  in_ch ();
  msbc_out_if out_ch ();

  merge_sort_by_count dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // --------------------------------------------------------------------------
  // Result side: random back-pressure, every accepted beat goes to the checker.
  // Sampled in the active region of the edge, so these are pre-edge values.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    sort_check_pkg::sorted_beat_t beat;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      beat.key   = out_ch.sorted_key;
      beat.tag   = out_ch.sorted_tag;
      beat.last  = out_ch.is_last;
      beat.cmps  = out_ch.comparisons_total;
      beat.moves = out_ch.moves_total;
      beat.ovf   = out_ch.overflowed;
      sorter.check_result(beat);
    end
    out_ch.ready <= steady || ($urandom_range(99) >= STALL_PCT);
  end

  // Watchdog: cycles with no beat on either channel
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: no beat for %0d cycles", quiet_cycles);
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // One beat on the input channel, with an optional random idle gap first.
  // Valid gets exactly one assignment per edge: either lowered for a gap or
  // raised with the next beat.
  task automatic send_item(input logic m, input logic [msbc_pkg::KEY_W-1:0] k,
                           input logic [msbc_pkg::TAG_W-1:0] t, input logic lst);
    while (!steady && $urandom_range(99) < STALL_PCT) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid       <= 1'b1;
    in_ch.mode        <= m;
    in_ch.record_key  <= k;
    in_ch.record_tag  <= t;
    in_ch.last_record <= lst;
    @(posedge clk);
    while (!in_ch.ready) begin
      @(posedge clk);
    end
    sorter.note_input(m, k, t, lst);
    items_sent++;
  endtask

  function automatic logic [msbc_pkg::KEY_W-1:0] pick_key(key_style_t style);
    case (style)
      KEYS_WIDE: return $urandom;
      KEYS_TIED: return $urandom_range(3);     // plenty of equal keys
      default: begin
        case ($urandom_range(3))
          0:       return '0;
          1:       return '1;
          2:       return 32'h8000_0000;
          default: return 32'h7FFF_FFFF;
        endcase
      end
    endcase
  endfunction

  // n loads, last mark on the final one; noise slips in stray reads,
  // which are ignored once the new batch has begun loading
  task automatic load_batch(int unsigned n, key_style_t style, bit noise);
    for (int unsigned i = 0; i < n; i++) begin
      if (noise && $urandom_range(9) == 0) begin
        send_item(msbc_pkg::MODE_READ, $urandom, $urandom, 1'($urandom_range(1)));
      end
      send_item(msbc_pkg::MODE_LOAD, pick_key(style), $urandom, i == n - 1);
    end
  endtask

  // last mark on a read means nothing, so it is randomised
  task automatic read_back(int unsigned n);
    for (int unsigned i = 0; i < n; i++) begin
      send_item(msbc_pkg::MODE_READ, $urandom, $urandom, 1'($urandom_range(1)));
    end
  endtask

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------
  initial begin
    int unsigned n;
    key_style_t  style;
    sorter            = new();
    items_sent        = 0;
    steady            <= 1'b0;
    rst_n             <= 1'b0;
    in_ch.valid       <= 1'b0;
    in_ch.mode        <= msbc_pkg::MODE_LOAD;
    in_ch.record_key  <= '0;
    in_ch.record_tag  <= '0;
    in_ch.last_record <= 1'b0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // ---- directed ----
    // read before any sort: no result
    send_item(msbc_pkg::MODE_READ, '1, '1, 1'b1);
    // key extremes plus a run of equal keys; ties must come out right run first
    send_item(msbc_pkg::MODE_LOAD, 32'hFFFF_FFFF, 32'h0000_0000, 1'b0);
    send_item(msbc_pkg::MODE_LOAD, 32'h0000_0000, 32'hFFFF_FFFF, 1'b0);
    send_item(msbc_pkg::MODE_LOAD, 32'h0000_0005, 32'h0000_0001, 1'b0);
    send_item(msbc_pkg::MODE_LOAD, 32'h0000_0005, 32'h0000_0002, 1'b0);
    send_item(msbc_pkg::MODE_LOAD, 32'h8000_0000, 32'hA5A5_5A5A, 1'b0);
    send_item(msbc_pkg::MODE_LOAD, 32'h0000_0005, 32'h0000_0003, 1'b1);
    read_back(7);                              // one read past the end
    // single record: new batch, no comparisons and no moves
    send_item(msbc_pkg::MODE_LOAD, 32'h1234_5678, 32'h9ABC_DEF0, 1'b1);
    read_back(2);
    // read mid-load is ignored; partial read, then the next batch takes over
    send_item(msbc_pkg::MODE_LOAD, 32'd7, 32'd70, 1'b0);
    send_item(msbc_pkg::MODE_READ, '0, '0, 1'b0);
    send_item(msbc_pkg::MODE_LOAD, 32'd3, 32'd30, 1'b0);
    send_item(msbc_pkg::MODE_LOAD, 32'd9, 32'd90, 1'b1);
    read_back(1);

    // ---- random batches ----
    // mostly small batches, now and then a larger one; a quiet stretch in
    // the middle runs with no idling at all
    while (items_sent < RANDOM_ITEMS) begin
      steady <= (items_sent >= 150 && items_sent < 260);
      n      = ($urandom_range(4) == 0) ? $urandom_range(64, 17) : $urandom_range(16, 1);
      style  = key_style_t'($urandom_range(2));
      load_batch(n, style, 1'b1);
      if ($urandom_range(9) < 2) begin
        read_back($urandom_range(n));          // partial read
      end else begin
        read_back(n + $urandom_range(2));      // full read, maybe past the end
      end
    end
    steady <= 1'b0;

    in_ch.valid <= 1'b0;
    while (sorter.pending.size() != 0) begin
      @(posedge clk);
    end
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sorter.errors == 0 && sorter.pending.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
